>>> hdl/fpdf_pkg.sv
package fpdf_pkg;

	localparam int MAX_DIGITS  = 10;
	localparam int VALUE_W     = 32;
	localparam int CHAR_W      = 8;
	localparam int CFG_W       = 4;
	localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
	localparam int DIGS_W      = 4 * MAX_DIGITS;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int CLAMP_W     = 6;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

	// q / 10 == (q * RECIP_10) >> RECIP_SHIFT, exact for every 32-bit q
	localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
	localparam int                 RECIP_SHIFT = 35;

	typedef enum logic [1:0] {
		REG_INT_DIGITS  = 2'd0,
		REG_FRAC_DIGITS = 2'd1,
		REG_TERM_MODE   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [CFG_W-1:0] int_digits;
		logic [CFG_W-1:0] frac_digits;
		logic             term_mode;
	} cfg_t;

	// digits packed with the most significant shown digit in the low nibble
	typedef struct packed {
		logic [DIGS_W-1:0] digs;
		logic              ovf;
		logic [CNT_W-1:0]  n_int;
		logic [CNT_W-1:0]  n_frac;
		logic              term;
	} job_t;

endpackage

>>> hdl/fpdf_front.sv
module fpdf_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [fpdf_pkg::VALUE_W-1:0] value,
	input  fpdf_pkg::cfg_t               cfg,
	input  logic                         full,
	output logic                         busy,
	output logic                         push,
	output fpdf_pkg::job_t               job
);

	logic                          busy_q;
	logic [fpdf_pkg::VALUE_W-1:0]  q_q;
	logic [fpdf_pkg::CNT_W-1:0]    cnt_q;
	logic [fpdf_pkg::CNT_W-1:0]    ni_q;
	logic [fpdf_pkg::CNT_W-1:0]    nf_q;
	logic [fpdf_pkg::CNT_W-1:0]    nd_q;
	logic                          term_q;
	logic [fpdf_pkg::DIGS_W-1:0]   digs_q;

	logic [fpdf_pkg::CLAMP_W-1:0]  ni_w;
	logic [fpdf_pkg::CLAMP_W-1:0]  nf_w;
	logic [fpdf_pkg::CLAMP_W-1:0]  room_w;
	logic [2*fpdf_pkg::VALUE_W-1:0] prod;
	logic [fpdf_pkg::VALUE_W-1:0]  quot;
	logic [fpdf_pkg::VALUE_W-1:0]  rem_w;
	logic                          accept;
	logic                          conv_done;

	always_comb begin
		ni_w = fpdf_pkg::CLAMP_W'(cfg.int_digits);
		if (ni_w == '0) begin
			ni_w = fpdf_pkg::CLAMP_W'(1);
		end
		if (ni_w > fpdf_pkg::CLAMP_W'(fpdf_pkg::MAX_DIGITS)) begin
			ni_w = fpdf_pkg::CLAMP_W'(fpdf_pkg::MAX_DIGITS);
		end
		room_w = fpdf_pkg::CLAMP_W'(fpdf_pkg::MAX_DIGITS) - ni_w;
		nf_w   = fpdf_pkg::CLAMP_W'(cfg.frac_digits);
		if (nf_w > room_w) begin
			nf_w = room_w;
		end
	end

	assign prod  = q_q * fpdf_pkg::RECIP_10;
	assign quot  = fpdf_pkg::VALUE_W'(prod >> fpdf_pkg::RECIP_SHIFT);
	assign rem_w = q_q - ((quot << 3) + (quot << 1));

	assign accept    = start && !busy_q;
	assign conv_done = (cnt_q == nd_q);
	assign busy      = busy_q;
	assign push      = busy_q && conv_done && !full;

	assign job.digs   = digs_q;
	assign job.ovf    = (q_q != '0);
	assign job.n_int  = ni_q;
	assign job.n_frac = nf_q;
	assign job.term   = term_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (push) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_q    <= value;
			cnt_q  <= '0;
			ni_q   <= fpdf_pkg::CNT_W'(ni_w);
			nf_q   <= fpdf_pkg::CNT_W'(nf_w);
			nd_q   <= fpdf_pkg::CNT_W'(ni_w + nf_w);
			term_q <= cfg.term_mode;
			digs_q <= '0;
		end else if (busy_q && !conv_done) begin
			q_q    <= quot;
			cnt_q  <= cnt_q + fpdf_pkg::CNT_W'(1);
			digs_q <= {digs_q[fpdf_pkg::DIGS_W-5:0], rem_w[3:0]};
		end
	end

endmodule

>>> hdl/fpdf_queue.sv
module fpdf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fpdf_pkg::job_t push_job,
	input  logic           pop,
	output fpdf_pkg::job_t pop_job,
	output logic           full,
	output logic           empty
);

	fpdf_pkg::job_t               entries_q [fpdf_pkg::QUEUE_DEPTH];
	logic [fpdf_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [fpdf_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [fpdf_pkg::QCNT_W-1:0]  count_q;

	function automatic logic [fpdf_pkg::QPTR_W-1:0] next_ptr(
		input logic [fpdf_pkg::QPTR_W-1:0] p
	);
		if (p == fpdf_pkg::QPTR_W'(fpdf_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + fpdf_pkg::QPTR_W'(1);
	endfunction

	assign full    = (count_q == fpdf_pkg::QCNT_W'(fpdf_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_job = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + fpdf_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - fpdf_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fpdf_pkg::QCNT_W'(fpdf_pkg::QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

>>> hdl/fpdf_back.sv
module fpdf_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        empty,
	input  fpdf_pkg::job_t              job,
	output logic                        pop,
	output logic                        strobe,
	output logic [fpdf_pkg::CHAR_W-1:0] char_code,
	output logic                        last,
	output logic                        overflow
);

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_INT  = 5'b00010,
		B_PNT  = 5'b00100,
		B_FRAC = 5'b01000,
		B_NUL  = 5'b10000
	} back_state_t;

	back_state_t                  state_q;
	back_state_t                  state_nx;
	logic [fpdf_pkg::DIGS_W-1:0]  digs_q;
	logic                         ovf_q;
	logic [fpdf_pkg::CNT_W-1:0]   int_left_q;
	logic [fpdf_pkg::CNT_W-1:0]   frac_left_q;
	logic                         has_point_q;
	logic                         term_q;

	logic                         strobe_q;
	logic [fpdf_pkg::CHAR_W-1:0]  char_q;
	logic                         last_q;
	logic                         overflow_q;

	logic                         emit;
	logic [fpdf_pkg::CHAR_W-1:0]  emit_char;
	logic                         emit_last;
	logic                         done;
	logic [fpdf_pkg::CHAR_W-1:0]  digit_char;

	assign digit_char = fpdf_pkg::CH_ZERO + fpdf_pkg::CHAR_W'(digs_q[3:0]);

	always_comb begin
		emit      = 1'b0;
		emit_char = fpdf_pkg::CH_NUL;
		emit_last = 1'b0;
		done      = 1'b0;
		state_nx  = state_q;
		case (state_q)
			B_IDLE: begin
				done = 1'b1;
			end
			B_INT: begin
				emit      = 1'b1;
				emit_char = digit_char;
				if (int_left_q == fpdf_pkg::CNT_W'(1)) begin
					if (has_point_q) begin
						state_nx = B_PNT;
					end else if (term_q) begin
						state_nx = B_NUL;
					end else begin
						emit_last = 1'b1;
						done      = 1'b1;
					end
				end
			end
			B_PNT: begin
				emit      = 1'b1;
				emit_char = fpdf_pkg::CH_POINT;
				state_nx  = B_FRAC;
			end
			B_FRAC: begin
				emit      = 1'b1;
				emit_char = digit_char;
				if (frac_left_q == fpdf_pkg::CNT_W'(1)) begin
					if (term_q) begin
						state_nx = B_NUL;
					end else begin
						emit_last = 1'b1;
						done      = 1'b1;
					end
				end
			end
			B_NUL: begin
				emit      = 1'b1;
				emit_char = fpdf_pkg::CH_NUL;
				emit_last = 1'b1;
				done      = 1'b1;
			end
			default: begin
				state_nx = B_IDLE;
			end
		endcase
		pop = done && !empty;
		if (done) begin
			state_nx = pop ? B_INT : B_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_nx;
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q     <= emit_char;
			last_q     <= emit_last;
			overflow_q <= ovf_q;
		end
		if (pop) begin
			digs_q      <= job.digs;
			ovf_q       <= job.ovf;
			int_left_q  <= job.n_int;
			frac_left_q <= job.n_frac;
			has_point_q <= (job.n_frac != '0);
			term_q      <= job.term;
		end else if (state_q == B_INT) begin
			digs_q     <= digs_q >> 4;
			int_left_q <= int_left_q - fpdf_pkg::CNT_W'(1);
		end else if (state_q == B_FRAC) begin
			digs_q      <= digs_q >> 4;
			frac_left_q <= frac_left_q - fpdf_pkg::CNT_W'(1);
		end
	end

	assign strobe    = strobe_q;
	assign char_code = char_q;
	assign last      = last_q;
	assign overflow  = overflow_q;

	a_nul_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && char_q == fpdf_pkg::CH_NUL) |-> last_q)
		else $error("NUL emitted before end of string");
	a_point_then_frac: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_PNT) |=> (state_q == B_FRAC))
		else $error("point not followed by fraction digits");
	a_int_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_INT) |-> (int_left_q != '0))
		else $error("integer digit count exhausted");

endmodule

>>> hdl/fixed_point_decimal_formatter.sv
// Fixed-point decimal formatter.
// Request channel: drive value and raise start; the request is taken at a
// rising edge where start is high and busy is low.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Index 0 int_digits, 1 frac_digits, 2 terminate_mode; index 3
// is ignored. Write only while the block is idle.
// Result channel: one character per cycle on char_code with last and overflow,
// valid for exactly one cycle while strobe is high. The receiver cannot stall.
// Conversion: after the accepting edge the converter does one divide-by-ten
// per digit (D = int_digits + frac_digits after clamping), then hands the job
// to the queue, waiting while the queue is full; busy stays high until the job
// is pushed. The emitter sends the D digits, a point when frac_digits is
// nonzero and a NUL when terminate_mode is set, back to back.
// A two-deep job queue lets the next value convert while the previous one is
// still being sent.
// Reset: int_digits 5, frac_digits 0, terminate_mode 1; queue and emitter
// are emptied.
module fixed_point_decimal_formatter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [fpdf_pkg::VALUE_W-1:0] value,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [fpdf_pkg::CFG_W-1:0]   cfg_data,
	output logic                         strobe,
	output logic [fpdf_pkg::CHAR_W-1:0]  char_code,
	output logic                         last,
	output logic                         overflow
);

	fpdf_pkg::cfg_t cfg_q;
	fpdf_pkg::job_t front_job;
	fpdf_pkg::job_t queue_job;
	logic           push;
	logic           pop;
	logic           full;
	logic           empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.int_digits  <= fpdf_pkg::CFG_W'(5);
			cfg_q.frac_digits <= '0;
			cfg_q.term_mode   <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fpdf_pkg::REG_INT_DIGITS:  cfg_q.int_digits  <= cfg_data;
				fpdf_pkg::REG_FRAC_DIGITS: cfg_q.frac_digits <= cfg_data;
				fpdf_pkg::REG_TERM_MODE:   cfg_q.term_mode   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	fpdf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.value  (value),
		.cfg    (cfg_q),
		.full   (full),
		.busy   (busy),
		.push   (push),
		.job    (front_job)
	);

	fpdf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (front_job),
		.pop      (pop),
		.pop_job  (queue_job),
		.full     (full),
		.empty    (empty)
	);

	fpdf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.job       (queue_job),
		.pop       (pop),
		.strobe    (strobe),
		.char_code (char_code),
		.last      (last),
		.overflow  (overflow)
	);

endmodule

>>> sim/fixed_point_decimal_formatter_tb.sv
`timescale 1ns / 100ps

module fixed_point_decimal_formatter_tb;

	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef struct {
		logic [fpdf_pkg::CHAR_W-1:0] code;
		logic                        last;
		logic                        ovf;
	} char_t;

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic [fpdf_pkg::VALUE_W-1:0]   value;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [1:0]                     cfg_index;
	logic [fpdf_pkg::CFG_W-1:0]     cfg_data;
	logic                           strobe;
	logic [fpdf_pkg::CHAR_W-1:0]    char_code;
	logic                           last;
	logic                           overflow;

	logic [fpdf_pkg::CFG_W-1:0]     fmt_int;
	logic [fpdf_pkg::CFG_W-1:0]     fmt_frac;
	logic                           fmt_term;
	char_t                          pending_chars[$];
	int                             n_errors;
	bit                             gaps_on;

	fixed_point_decimal_formatter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.strobe    (strobe),
		.char_code (char_code),
		.last      (last),
		.overflow  (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic void field_widths(output int ni, output int nf);
		ni = int'(fmt_int);
		if (ni < 1)
			ni = 1;
		if (ni > fpdf_pkg::MAX_DIGITS)
			ni = fpdf_pkg::MAX_DIGITS;
		nf = int'(fmt_frac);
		if (nf > fpdf_pkg::MAX_DIGITS - ni)
			nf = fpdf_pkg::MAX_DIGITS - ni;
	endfunction

	function automatic void predict_string(input logic [fpdf_pkg::VALUE_W-1:0] v);
		int                           ni, nf, nd, total, k;
		logic [3:0]                   digs [fpdf_pkg::MAX_DIGITS];
		logic [fpdf_pkg::VALUE_W-1:0] q;
		logic                         ovf;
		char_t                        c;
		field_widths(ni, nf);
		nd = ni + nf;
		q = v;
		for (int i = 0; i < nd; i++) begin
			digs[i] = 4'(q % 10);
			q = q / 10;
		end
		ovf = (q != 0);
		total = nd + int'(nf > 0) + int'(fmt_term);
		k = 0;
		for (int i = 0; i < nd; i++) begin
			if (i == ni && nf > 0) begin
				c = '{fpdf_pkg::CH_POINT, k == total - 1, ovf};
				pending_chars.push_back(c);
				k++;
			end
			c = '{fpdf_pkg::CH_ZERO + digs[nd - 1 - i], k == total - 1, ovf};
			pending_chars.push_back(c);
			k++;
		end
		if (fmt_term) begin
			c = '{fpdf_pkg::CH_NUL, 1'b1, ovf};
			pending_chars.push_back(c);
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $realtime, msg);
		n_errors++;
	endtask

	always @(posedge clk) begin
		char_t c;
		if (arst_n && strobe) begin
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected char %h", char_code));
			end else begin
				c = pending_chars.pop_front();
				if (char_code !== c.code || last !== c.last || overflow !== c.ovf)
					report_mismatch($sformatf("got %h/%b/%b expected %h/%b/%b",
						char_code, last, overflow, c.code, c.last, c.ovf));
			end
		end
	end

	// request stays high on return so the next one can follow without a gap
	task automatic send_value(input logic [fpdf_pkg::VALUE_W-1:0] v);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		value <= v;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_string(v);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [fpdf_pkg::CFG_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			fpdf_pkg::REG_INT_DIGITS:  fmt_int  = d;
			fpdf_pkg::REG_FRAC_DIGITS: fmt_frac = d;
			fpdf_pkg::REG_TERM_MODE:   fmt_term = d[0];
			default: ;
		endcase
	endtask

	task automatic set_format(input logic [fpdf_pkg::CFG_W-1:0] i,
			input logic [fpdf_pkg::CFG_W-1:0] f, input logic [fpdf_pkg::CFG_W-1:0] t);
		write_reg(fpdf_pkg::REG_INT_DIGITS, i);
		write_reg(fpdf_pkg::REG_FRAC_DIGITS, f);
		write_reg(fpdf_pkg::REG_TERM_MODE, t);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [fpdf_pkg::VALUE_W-1:0] random_value();
		int           ni, nf;
		longint       p;
		logic [63:0]  r;
		field_widths(ni, nf);
		p = 1;
		repeat (ni + nf) p = p * 10;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 99);
			2: return (p - 1 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(p - 1);
			3: return (p > 64'hFFFF_FFFF) ? $urandom : 32'(p);
			4: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			default: return (p > 64'hFFFF_FFFF) ? $urandom : 32'(r % p);
		endcase
	endfunction

	task automatic test_reset_format();
		send_value(32'd0);
		send_value(32'd12345);
		send_value(32'd99999);
		send_value(32'd100000);
		send_value(32'hFFFF_FFFF);
		drain_results();
	endtask

	task automatic test_field_extremes();
		set_format(4'd10, 4'd0, 4'd1);
		send_value(32'hFFFF_FFFF);
		send_value(32'd1);
		drain_results();
		set_format(4'd1, 4'd9, 4'd0);
		send_value(32'hFFFF_FFFF);
		send_value(32'd0);
		drain_results();
		// zero int digits shows one
		set_format(4'd0, 4'd3, 4'hF);
		send_value(32'd9999);
		send_value(32'd10000);
		drain_results();
		// int digits clamp, fraction squeezed to nothing
		set_format(4'd15, 4'd5, 4'hE);
		send_value(32'd1234567890);
		send_value(32'd7);
		drain_results();
		// fraction clamps to fit
		set_format(4'd4, 4'd15, 4'd1);
		send_value(32'd3141592653);
		send_value(32'd1000000000);
		drain_results();
		set_format(4'd1, 4'd0, 4'd0);
		send_value(32'd9);
		send_value(32'd10);
		drain_results();
	endtask

	task automatic test_spare_index();
		write_reg(REG_SPARE, 4'hA);
		cfg_valid <= 1'b0;
		send_value(32'd42);
		send_value(32'd1234567);
		drain_results();
	endtask

	task automatic test_random_formats(input int n_items);
		int sent;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 5) == 0)
				write_reg(REG_SPARE, 4'($urandom));
			if ($urandom_range(0, 4) == 0)
				set_format(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					4'($urandom));
			else
				set_format(4'($urandom_range(1, 10)), 4'($urandom_range(0, 9)),
					4'($urandom));
			gaps_on = $urandom_range(0, 3) != 0;
			repeat ($urandom_range(10, 40)) begin
				if (sent < n_items) begin
					send_value(random_value());
					sent++;
				end
			end
			drain_results();
		end
	endtask

	task automatic test_back_to_back();
		gaps_on = 1'b0;
		set_format(4'd4, 4'd6, 4'd1);
		repeat (10) send_value(random_value());
		drain_results();
		set_format(4'd1, 4'd0, 4'd0);
		repeat (10) send_value(random_value());
		drain_results();
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		value     = '0;
		cfg_valid = 1'b0;
		cfg_index = fpdf_pkg::REG_INT_DIGITS;
		cfg_data  = '0;
		fmt_int   = 4'd5;
		fmt_frac  = 4'd0;
		fmt_term  = 1'b1;
		n_errors  = 0;
		gaps_on   = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_format();
		test_field_extremes();
		test_spare_index();
		test_random_formats(280);
		test_back_to_back();

		repeat (20) @(posedge clk);
		if (n_errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
